// ----- sv/signed_int_to_decimal_ascii_unit_macros.svh -----
// Assertion helpers shared by the conversion unit.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SIDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/sidc_pkg.sv -----
package sidc_pkg;

	localparam int VALUE_WIDTH = 32;
	// Enough decimal digits for a magnitude of up to 2^(VALUE_WIDTH-1).
	localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
	localparam int BCD_W = NUM_DIGITS * 4;
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int DIG_IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int NDIG_W = $clog2(NUM_DIGITS + 1);
	localparam int COUNT_W = 4;
	localparam int CH_W = 8;

	localparam logic [CH_W-1:0] ASCII_ZERO = 8'd48;
	localparam logic [CH_W-1:0] ASCII_MINUS = 8'd45;

	typedef struct packed {
		logic done;
		logic [BCD_W-1:0] bcd;
	} conv_stat_t;

endpackage

// ----- sv/signed_int_to_decimal_ascii_unit.sv -----
// Converts one signed 32-bit integer per transfer into its decimal ASCII text, most
// significant character first, with a leading '-' for negative values; the final
// character has last set and carries the character count. The magnitude goes through
// a bit-serial double-dabble register, one bit per cycle; then the digit count is
// registered and the characters leave one per cycle while out_stall is low, through
// an output register. An item has 1 to 11 characters. The next value is taken as soon
// as the final character sits in the output register, even while that character waits.
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module signed_int_to_decimal_ascii_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [sidc_pkg::VALUE_WIDTH-1:0] value,
	output logic out_valid,
	input  logic out_stall,
	output logic [sidc_pkg::CH_W-1:0] ch,
	output logic last,
	output logic [sidc_pkg::COUNT_W-1:0] char_count
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic neg_q;
	logic [sidc_pkg::DIG_IDX_W-1:0] idx_q;
	logic [sidc_pkg::COUNT_W-1:0] total_q;
	logic out_valid_q;
	logic [sidc_pkg::CH_W-1:0] ch_q;
	logic last_q;
	logic [sidc_pkg::COUNT_W-1:0] count_q;

	logic accept;
	logic load;
	logic [sidc_pkg::VALUE_WIDTH-1:0] v_u;
	logic [sidc_pkg::VALUE_WIDTH-1:0] mag;
	sidc_pkg::conv_stat_t stat;
	logic [sidc_pkg::NDIG_W-1:0] ndig;
	logic [sidc_pkg::COUNT_W+sidc_pkg::NDIG_W-1:0] total_full;
	logic [3:0] cur_digit;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign load = !out_valid_q || !out_stall;

	assign v_u = value;
	assign mag = v_u[sidc_pkg::VALUE_WIDTH-1] ? (~v_u + 1'b1) : v_u;

	sidc_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.stat   (stat)
	);

	// Significant digits: position of the highest nonzero digit, at least one.
	always_comb begin
		ndig = sidc_pkg::NDIG_W'(1);
		for (int i = 1; i < sidc_pkg::NUM_DIGITS; i++) begin
			if (stat.bcd[i*4 +: 4] != 4'd0) begin
				ndig = sidc_pkg::NDIG_W'(i + 1);
			end
		end
	end

	assign total_full = (sidc_pkg::COUNT_W+sidc_pkg::NDIG_W)'(ndig)
		+ (sidc_pkg::COUNT_W+sidc_pkg::NDIG_W)'(neg_q);
	assign cur_digit = stat.bcd[idx_q*4 +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= (state_q == ST_EMIT);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (stat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load && !neg_q && idx_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= v_u[sidc_pkg::VALUE_WIDTH-1];
		end
		if (state_q == ST_CONV && stat.done) begin
			idx_q <= sidc_pkg::DIG_IDX_W'(ndig - 1'b1);
			total_q <= total_full[sidc_pkg::COUNT_W-1:0];
		end
		if (state_q == ST_EMIT && load) begin
			if (neg_q) begin
				// sign goes first, then advance to the digits
				ch_q <= sidc_pkg::ASCII_MINUS;
				last_q <= 1'b0;
				count_q <= '0;
				neg_q <= 1'b0;
			end else begin
				ch_q <= sidc_pkg::ASCII_ZERO + sidc_pkg::CH_W'(cur_digit);
				last_q <= (idx_q == '0);
				count_q <= (idx_q == '0) ? total_q : '0;
				if (idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign ch = ch_q;
	assign last = last_q;
	assign char_count = count_q;

	`SIDC_ASSERT_NOW(a_done_in_conv, stat.done, state_q == ST_CONV, "conversion done outside CONV")
	`SIDC_ASSERT_NOW(a_minus_not_last, out_valid && ch == sidc_pkg::ASCII_MINUS, !last, "sign marked last")
	`SIDC_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_CONV, "transfer did not start conversion")

endmodule

// ----- sv/sidc_dabble.sv -----
module sidc_dabble (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [sidc_pkg::VALUE_WIDTH-1:0] mag,
	output sidc_pkg::conv_stat_t stat
);

	logic busy_q;
	logic done_q;
	logic [sidc_pkg::CNT_W-1:0] cnt_q;
	logic [sidc_pkg::VALUE_WIDTH-1:0] shift_q;
	logic [sidc_pkg::BCD_W-1:0] bcd_q;
	logic [sidc_pkg::BCD_W-1:0] bcd_adj;
	logic [sidc_pkg::BCD_W-1:0] bcd_next;

	// Add 3 to every digit of five or more, then shift in the next magnitude bit.
	always_comb begin
		logic [3:0] d;
		for (int i = 0; i < sidc_pkg::NUM_DIGITS; i++) begin
			d = bcd_q[i*4 +: 4];
			bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
		bcd_next = {bcd_adj[sidc_pkg::BCD_W-2:0], shift_q[sidc_pkg::VALUE_WIDTH-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == sidc_pkg::CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= sidc_pkg::CNT_W'(sidc_pkg::VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == sidc_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[sidc_pkg::VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= bcd_next;
		end
	end

	assign stat.done = done_q;
	assign stat.bcd = bcd_q;

endmodule

// ----- dv/signed_int_to_decimal_ascii_unit_test.sv -----
module signed_int_to_decimal_ascii_unit_test;
	import sidc_pkg::*;

	typedef struct {
		logic [CH_W-1:0] ch;
		logic last;
		logic [COUNT_W-1:0] char_count;
	} text_char_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [VALUE_WIDTH-1:0] value;
	logic out_valid;
	logic out_stall;
	logic [CH_W-1:0] ch;
	logic last;
	logic [COUNT_W-1:0] char_count;

	text_char_t expected_text[$];
	int fail_count = 0;
	bit sender_gaps = 1'b1;
	bit stall_bursts = 1'b1;

	signed_int_to_decimal_ascii_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ch(ch),
		.last(last),
		.char_count(char_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Queue the characters that one value must produce, leading sign first.
	function automatic void spell_decimal(input logic [VALUE_WIDTH-1:0] v);
		logic [VALUE_WIDTH-1:0] mag;
		logic neg;
		logic [3:0] digits [0:19];
		int nd;
		int total;
		neg = v[VALUE_WIDTH-1];
		mag = neg ? (~v + 1'b1) : v;
		nd = 0;
		do begin
			digits[nd] = 4'(mag % 10);
			nd++;
			mag = mag / 10;
		end while (mag != 0 && nd < 20);
		total = nd + (neg ? 1 : 0);
		if (neg) begin
			expected_text.push_back('{ch: ASCII_MINUS, last: 1'b0, char_count: '0});
		end
		for (int i = nd - 1; i >= 0; i--) begin
			expected_text.push_back('{ch: ASCII_ZERO + CH_W'(digits[i]),
				last: (i == 0),
				char_count: (i == 0) ? COUNT_W'(total) : '0});
		end
	endfunction

	// A quarter of the time raw bits, otherwise a uniformly sized decimal length.
	function automatic logic [VALUE_WIDTH-1:0] random_value();
		longint p;
		longint lo;
		longint hi;
		int d;
		logic [VALUE_WIDTH-1:0] v;
		if ($urandom_range(3, 0) == 0) begin
			v = $urandom;
		end else begin
			d = $urandom_range(10, 1);
			p = 1;
			repeat (d - 1) p = p * 10;
			lo = (d == 1) ? 0 : p;
			hi = p * 10 - 1;
			if (hi > 64'd2147483647)
				hi = 64'd2147483647;
			v = $urandom_range(32'(hi), 32'(lo));
			if ($urandom_range(1, 0) == 1)
				v = -v;
		end
		return v;
	endfunction

	task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		spell_decimal(v);
	endtask

	task automatic maybe_hold_off();
		if (sender_gaps && $urandom_range(2, 0) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(14, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_values();
		logic [VALUE_WIDTH-1:0] corners [20];
		corners = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
			32'sd99, 32'sd100, 32'sd101, 32'sd12345, -32'sd67890, 32'sd999999999,
			32'sd1000000000, -32'sd1000000000, 32'sd1234567890, -32'sd1234567890,
			32'sh7fff_ffff, 32'sh8000_0001, 32'sh8000_0000};
		foreach (corners[i]) begin
			send_value(corners[i]);
			maybe_hold_off();
		end
	endtask

	task automatic test_random_magnitudes();
		repeat (100) begin
			send_value(random_value());
			maybe_hold_off();
		end
	endtask

	task automatic test_pause_until_drained();
		repeat (2) begin
			repeat (5) begin
				send_value(random_value());
				maybe_hold_off();
			end
			wait_for_drain();
		end
	endtask

	task automatic test_back_to_back();
		sender_gaps = 1'b0;
		stall_bursts = 1'b0;
		repeat (30) send_value(random_value());
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_bursts && $urandom_range(3, 0) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(14, 1)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				$error("unexpected character transfer: ch=0x%0h last=%0b char_count=%0d",
					ch, last, char_count);
				fail_count++;
			end else begin
				want = expected_text.pop_front();
				if (ch !== want.ch) begin
					$error("ch: expected 0x%0h, got 0x%0h", want.ch, ch);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					fail_count++;
				end
				if (char_count !== want.char_count) begin
					$error("char_count: expected %0d, got %0d", want.char_count, char_count);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#(12 * 400000);
		$display("FAIL signed_int_to_decimal_ascii_unit");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_values();
		test_random_magnitudes();
		test_pause_until_drained();
		test_back_to_back();
		wait_for_drain();
		// catch any stray transfer after the last character
		repeat (60) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS signed_int_to_decimal_ascii_unit");
		end else begin
			$display("FAIL signed_int_to_decimal_ascii_unit");
		end
		$finish;
	end

endmodule

// ----- signed_int_to_decimal_ascii_unit.f -----
+incdir+sv
sv/sidc_pkg.sv
sv/sidc_dabble.sv
sv/signed_int_to_decimal_ascii_unit.sv
dv/signed_int_to_decimal_ascii_unit_test.sv
